[src/nnrms_pkg.sv]
// Package for the nearest-neighbor RMS error core: request/result structs and constants.
// No dependencies.
`default_nettype none
package nnrms_pkg;
    localparam int CRD_W   = 16;
    localparam int RANGE_W = 35;
    localparam int SUM_W   = 52;
    localparam int CNT_W   = 16;
    localparam int RMS_W   = 18;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SOURCE = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic                    first;
        logic                    last;
        logic                    coord_invalid;
        logic signed [CRD_W-1:0] px;
        logic signed [CRD_W-1:0] py;
        logic signed [CRD_W-1:0] pz;
    } req_t;

    typedef struct packed {
        logic [RMS_W-1:0] rms_distance;
        logic [CNT_W-1:0] matched_count;
        logic             no_match;
    } res_t;

    // start request from control to the divide/sqrt unit
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } fin_req_t;
endpackage
`default_nettype wire

[src/nnrms_ram.sv]
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module nnrms_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/nnrms_finish.sv]
// Result unit: restoring divide sum/count then bit-pair integer square root.
// Depends on nnrms_pkg.
`default_nettype none
module nnrms_finish
    import nnrms_pkg::*;
(
    input  wire      clk,
    input  wire      rst_n,
    input  fin_req_t fin,
    output logic     busy,
    output logic     done,
    output res_t     res
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SQRT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [5:0]       step_reg, step_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] den_reg, den_next;
    logic [SUM_W-1:0] sv_reg, sv_next;
    logic [SUM_W-1:0] root_reg, root_next;
    logic [SUM_W-1:0] bit_reg, bit_next;
    logic             done_reg, done_next;
    res_t             res_reg, res_next;

    logic [CNT_W:0]   rem_sh;
    logic [SUM_W-1:0] trial;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        sv_next    = sv_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        rem_sh     = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
        trial      = root_reg + bit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (fin.start)
                begin
                    if (fin.count == '0)
                    begin
                        res_next  = '{rms_distance: '0, matched_count: '0, no_match: 1'b1};
                        done_next = 1'b1;
                    end
                    else
                    begin
                        quo_next   = fin.sum;
                        rem_next   = '0;
                        den_next   = fin.count;
                        step_next  = 6'(SUM_W - 1);
                        state_next = S_DIV;
                        res_next.matched_count = fin.count;
                        res_next.no_match      = 1'b0;
                    end
                end
            end
            S_DIV:
            begin
                // one quotient bit per cycle
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                step_next = step_reg - 6'd1;
                if (step_reg == '0)
                begin
                    sv_next    = quo_next;
                    root_next  = '0;
                    bit_next   = SUM_W'(1) << (SUM_W - 2);
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sv_reg >= trial)
                begin
                    sv_next   = sv_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    res_next.rms_distance = root_next[RMS_W-1:0];
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        sv_reg   <= sv_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        res_reg  <= res_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

    a_rem_lt_den: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < {1'b0, den_reg})
        else $error("divider remainder out of range");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fin.start |-> state_reg == S_IDLE)
        else $error("start while busy");
endmodule
`default_nettype wire

[src/nearest_neighbor_rms_error_core.sv]
// Nearest-neighbor RMS error core: target store scan, match accumulation, result.
// Depends on nnrms_pkg, nnrms_ram, nnrms_finish.
// A target load is written as it is accepted; a source point scans the N stored
//   targets, one store read per cycle feeding a two-stage distance/min pipeline.
// A last request then runs the divide and the square root.
// Throughput: one request at a time; in_stall is high whenever control is not idle.
// Reset: counts, sum and control clear; range register sets to all ones; store contents undefined.
`default_nettype none
module nearest_neighbor_rms_error_core
    import nnrms_pkg::*;
#(
    parameter int TARGET_POINTS = 4096
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  req_t                in_data,
    output logic                out_valid,
    input  wire                 out_stall,
    output res_t                out_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [RANGE_W-1:0]   cfg_data
);
    localparam int AW  = (TARGET_POINTS > 1) ? $clog2(TARGET_POINTS) : 1;
    localparam int TCW = $clog2(TARGET_POINTS + 1);
    localparam int CW  = CRD_W;
    localparam int DW  = CW + 1;
    localparam int SQW = 2 * DW;
    localparam int DSW = SQW + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [TCW-1:0]     tcount_reg, tcount_next;
    logic [TCW-1:0]     idx_reg, idx_next;
    logic [RANGE_W-1:0] range_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               last_reg, last_next;
    logic [CW-1:0]      sx_reg, sy_reg, sz_reg;
    logic [DSW-1:0]     best_reg, best_next;
    logic               v1_reg, v2_reg;
    logic [DSW-1:0]     d_reg;
    logic [SQW-1:0]     qx_reg, qy_reg, qz_reg;
    logic               out_valid_reg, out_valid_next;
    res_t               out_reg;

    logic               accept;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [TCW-1:0]     wbase;
    logic [3*CW-1:0]    rdata;
    logic signed [DW-1:0] dx, dy, dz;
    logic [DW-1:0]      ax, ay, az;
    fin_req_t           fin;
    logic               fin_busy, fin_done;
    res_t               fin_res;
    logic [SUM_W:0]     sum_add;
    // read issued last cycle is valid data now
    logic               v1_src;
    logic               rd_valid_reg;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign wbase = in_data.first ? '0 : tcount_reg;
    assign we    = accept && in_data.cmd == CMD_LOAD && wbase < TCW'(TARGET_POINTS);
    assign waddr = wbase[AW-1:0];

    nnrms_ram #(.WIDTH(3 * CW), .DEPTH(TARGET_POINTS)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata ({in_data.px[CW-1:0], in_data.py[CW-1:0], in_data.pz[CW-1:0]}),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign dx = DW'($signed(sx_reg)) - DW'($signed(rdata[3*CW-1:2*CW]));
    assign dy = DW'($signed(sy_reg)) - DW'($signed(rdata[2*CW-1:CW]));
    assign dz = DW'($signed(sz_reg)) - DW'($signed(rdata[CW-1:0]));
    assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
    assign az = dz[DW-1] ? DW'(-dz) : DW'(dz);

    assign v1_src = rd_valid_reg;

    // stage 1: squares; stage 2: sum; min tracked in best_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_src;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg <= ax * ax;
        qy_reg <= ay * ay;
        qz_reg <= az * az;
        d_reg  <= DSW'(qx_reg) + DSW'(qy_reg) + DSW'(qz_reg);
    end

    assign sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(best_reg);

    always_comb
    begin
        state_next     = state_reg;
        tcount_next    = tcount_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && out_stall;
        fin            = '{start: 1'b0, sum: sum_reg, count: cnt_reg};
        if (v2_reg && d_reg < best_reg)
        begin
            best_next = d_reg;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.cmd == CMD_LOAD)
                    begin
                        if (we)
                        begin
                            tcount_next = wbase + TCW'(1);
                        end
                        else
                        begin
                            tcount_next = wbase;
                        end
                    end
                    else
                    begin
                        last_next = in_data.last;
                        best_next = '1;
                        idx_next  = '0;
                        if (!in_data.coord_invalid && tcount_reg != '0)
                        begin
                            state_next = S_SCAN;
                        end
                        else if (in_data.last)
                        begin
                            state_next = S_FIN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (idx_reg != tcount_reg)
                begin
                    idx_next = idx_reg + TCW'(1);
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (best_reg <= DSW'(range_reg) && cnt_reg != '1)
                begin
                    sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (!out_valid_reg && !fin_busy)
                begin
                    fin.start  = 1'b1;
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (fin_done)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    nnrms_finish u_finish (
        .clk   (clk),
        .rst_n (rst_n),
        .fin   (fin),
        .busy  (fin_busy),
        .done  (fin_done),
        .res   (fin_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tcount_reg    <= '0;
            idx_reg       <= '0;
            range_reg     <= '1;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tcount_reg    <= tcount_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            rd_valid_reg  <= (state_reg == S_SCAN) && (idx_reg != tcount_reg);
            if (cfg_valid && cfg_ready)
            begin
                range_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        if (accept && in_data.cmd == CMD_SOURCE)
        begin
            sx_reg <= in_data.px[CW-1:0];
            sy_reg <= in_data.py[CW-1:0];
            sz_reg <= in_data.pz[CW-1:0];
        end
        if (fin_done)
        begin
            out_reg <= fin_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> idx_reg <= tcount_reg)
        else $error("scan index beyond target count");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tcount_reg <= TCW'(TARGET_POINTS))
        else $error("target count overflow");
    a_acc_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC |-> !v1_reg && !v2_reg)
        else $error("accumulate before pipeline drained");
endmodule
`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for nearest_neighbor_rms_error_core: target loads, source scans,
// range cutoff, invalid and empty-store cases, with random gaps and receiver stalls.
// Depends on nnrms_pkg and the core RTL.
`timescale 1ns / 100ps
module tb_top;
    import nnrms_pkg::*;

    localparam int  STORE_DEPTH = 4096;
    localparam int  COUNT_FULL  = 65535;
    localparam longint unsigned SUM_FULL  = (64'd1 << SUM_W) - 1;
    localparam longint unsigned RANGE_TOP = (64'd1 << RANGE_W) - 1;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct {
        req_t req;
        int   gap;
    } pending_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    req_t               in_data;
    logic               out_valid;
    logic               out_stall;
    res_t               out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [RANGE_W-1:0] cfg_data;

    nearest_neighbor_rms_error_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state
    int              tgt_x [STORE_DEPTH];
    int              tgt_y [STORE_DEPTH];
    int              tgt_z [STORE_DEPTH];
    int              tgt_count;
    longint unsigned dist_sum;
    int              match_cnt;
    longint unsigned range_sq;

    pending_t        send_queue[$];
    res_t            rms_expected[$];
    int              fails;
    int              sent_items;
    int              results_seen;
    int              gap_left;
    int              wait_left;
    bit              tx_idle;
    bit              rx_idle;
    bit              hold_go;
    logic            rx_hold;
    longint          cycles;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // apply one accepted request to the predictor
    task automatic predict_request(input req_t r);
        longint unsigned best;
        longint unsigned d;
        longint          dx;
        longint          dy;
        longint          dz;
        res_t            e;
        if (r.cmd == CMD_LOAD) begin
            if (r.first)
                tgt_count = 0;
            if (tgt_count < STORE_DEPTH) begin
                tgt_x[tgt_count] = r.px;
                tgt_y[tgt_count] = r.py;
                tgt_z[tgt_count] = r.pz;
                tgt_count++;
            end
        end else begin
            if (!r.coord_invalid && tgt_count > 0) begin
                best = '1;
                for (int i = 0; i < tgt_count; i++) begin
                    dx = longint'(r.px) - tgt_x[i];
                    dy = longint'(r.py) - tgt_y[i];
                    dz = longint'(r.pz) - tgt_z[i];
                    d = dx * dx + dy * dy + dz * dz;
                    if (d < best)
                        best = d;
                end
                if (best <= range_sq && match_cnt < COUNT_FULL) begin
                    dist_sum = dist_sum + best;
                    if (dist_sum > SUM_FULL)
                        dist_sum = SUM_FULL;
                    match_cnt++;
                end
            end
            if (r.last) begin
                if (match_cnt == 0) begin
                    e.rms_distance  = '0;
                    e.matched_count = '0;
                    e.no_match      = 1'b1;
                end else begin
                    e.rms_distance  = RMS_W'(int_sqrt(dist_sum / match_cnt));
                    e.matched_count = CNT_W'(match_cnt);
                    e.no_match      = 1'b0;
                end
                rms_expected = {rms_expected, e};
                dist_sum  = 0;
                match_cnt = 0;
            end
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // request driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            gap_left <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_request(in_data);
                sent_items++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (send_queue.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data  <= send_queue[0].req;
                    gap_left <= send_queue[0].gap;
                    void'(send_queue.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk or negedge rst_n) begin
        res_t e;
        int   w;
        if (!rst_n) begin
            out_stall <= 1'b0;
            wait_left <= 0;
        end else begin
            w = wait_left;
            if (out_valid && !out_stall) begin
                results_seen++;
                if (rms_expected.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, out_data);
                    fails++;
                end else begin
                    e = rms_expected.pop_front();
                    if (out_data.rms_distance !== e.rms_distance) begin
                        $display("%0t: rms_distance expected %0d actual %0d", $time,
                                 e.rms_distance, out_data.rms_distance);
                        fails++;
                    end
                    if (out_data.matched_count !== e.matched_count) begin
                        $display("%0t: matched_count expected %0d actual %0d", $time,
                                 e.matched_count, out_data.matched_count);
                        fails++;
                    end
                    if (out_data.no_match !== e.no_match) begin
                        $display("%0t: no_match expected %0b actual %0b", $time,
                                 e.no_match, out_data.no_match);
                        fails++;
                    end
                end
                w = rx_idle ? $urandom_range(0, 14) : 0;
            end else if (out_valid && w > 0) begin
                w = w - 1;
            end
            wait_left <= w;
            out_stall <= rx_hold || (out_valid && w > 0);
        end
    end

    // long receiver hold-off, so the core backs up into its input
    initial begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_req(input logic cmd, input logic first, input logic last,
                             input logic bad, input int x, input int y, input int z);
        pending_t p;
        p.req.cmd           = cmd;
        p.req.first         = first;
        p.req.last          = last;
        p.req.coord_invalid = bad;
        p.req.px            = CRD_W'(x);
        p.req.py            = CRD_W'(y);
        p.req.pz            = CRD_W'(z);
        p.gap               = tx_idle ? int'($urandom_range(0, 14)) : 0;
        send_queue = {send_queue, p};
    endtask

    // wait for the core to go idle: all sent, all results in, scan drained
    task automatic drain_core();
        do
            @(negedge clk);
        while (send_queue.size() > 0 || in_valid || in_stall || out_valid
               || rms_expected.size() > 0);
        repeat (tgt_count + 150) @(posedge clk);
    endtask

    task automatic write_range(input longint unsigned v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v[RANGE_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        range_sq = v & RANGE_TOP;
    endtask

    function automatic int rand_coord();
        return $signed(16'($urandom));
    endfunction

    function automatic int near_coord(input int c, input int spread);
        int v;
        v = c + $urandom_range(0, 2 * spread) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    // random frames: a target set (in most frames), then a source run ending in last
    task automatic random_frames(input int frames);
        int n;
        int m;
        int k;
        int spread;
        for (int f = 0; f < frames; f++) begin
            n = $urandom_range(1, 10);
            spread = ($urandom_range(0, 1) == 1) ? 40 : 3000;
            if ($urandom_range(0, 5) != 0)
                for (int i = 0; i < n; i++)
                    queue_req(CMD_LOAD, i == 0, 1'($urandom_range(0, 1)), 1'b0,
                              rand_coord(), rand_coord(), rand_coord());
            m = $urandom_range(1, 7);
            for (int i = 0; i < m; i++) begin
                k = $urandom_range(0, tgt_count > 0 ? tgt_count - 1 : 0);
                if ($urandom_range(0, 3) == 0)
                    queue_req(CMD_SOURCE, 1'($urandom_range(0, 1)), i == m - 1,
                              $urandom_range(0, 6) == 0,
                              rand_coord(), rand_coord(), rand_coord());
                else
                    queue_req(CMD_SOURCE, 1'($urandom_range(0, 1)), i == m - 1,
                              $urandom_range(0, 6) == 0,
                              near_coord(tgt_x[k], spread), near_coord(tgt_y[k], spread),
                              near_coord(tgt_z[k], spread));
            end
            // occasional stray request between frames
            if ($urandom_range(0, 4) == 0)
                queue_req(1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'($urandom_range(0, 1)),
                          rand_coord(), rand_coord(), rand_coord());
            drain_core();
        end
    endtask

    initial begin
        fails        = 0;
        sent_items   = 0;
        results_seen = 0;
        cycles       = 0;
        tgt_count    = 0;
        dist_sum     = 0;
        match_cnt    = 0;
        range_sq     = RANGE_TOP;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        hold_go      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, extremes, invalid last, ignored flags
        queue_req(CMD_SOURCE, 1'b0, 1'b1, 1'b0, 5, 5, 5);
        queue_req(CMD_LOAD, 1'b1, 1'b1, 1'b0, -32768, -32768, -32768);
        queue_req(CMD_LOAD, 1'b0, 1'b0, 1'b1, 32767, 32767, 32767);
        queue_req(CMD_SOURCE, 1'b1, 1'b0, 1'b0, 32767, -32768, 0);
        queue_req(CMD_SOURCE, 1'b0, 1'b0, 1'b0, -32768, -32768, -32768);
        queue_req(CMD_SOURCE, 1'b0, 1'b1, 1'b1, 0, 0, 0);
        queue_req(CMD_LOAD, 1'b1, 1'b0, 1'b0, 0, 0, 0);
        queue_req(CMD_SOURCE, 1'b0, 1'b0, 1'b1, 100, 100, 100);
        queue_req(CMD_SOURCE, 1'b0, 1'b1, 1'b1, 1, 2, 3);
        queue_req(CMD_SOURCE, 1'b0, 1'b1, 1'b0, 32767, 32767, 32767);
        drain_core();

        write_range(0);
        queue_req(CMD_LOAD, 1'b1, 1'b0, 1'b0, 10, -20, 30);
        queue_req(CMD_LOAD, 1'b0, 1'b0, 1'b0, -7, 7, 0);
        queue_req(CMD_SOURCE, 1'b0, 1'b0, 1'b0, 10, -20, 30);
        queue_req(CMD_SOURCE, 1'b0, 1'b0, 1'b0, 11, -20, 30);
        queue_req(CMD_SOURCE, 1'b0, 1'b1, 1'b0, -7, 7, 0);
        queue_req(CMD_SOURCE, 1'b0, 1'b1, 1'b0, -7, 7, 1);
        drain_core();

        write_range(1);
        queue_req(CMD_SOURCE, 1'b0, 1'b0, 1'b0, -7, 7, 1);
        queue_req(CMD_SOURCE, 1'b0, 1'b1, 1'b0, -7, 8, 1);
        drain_core();

        write_range(RANGE_TOP);
        random_frames(3);
        write_range(2000);
        random_frames(3);
        write_range({$urandom, $urandom} & RANGE_TOP);
        random_frames(2);

        // receiver holds off while the sender keeps offering result requests
        write_range(RANGE_TOP);
        tx_idle = 1'b0;
        queue_req(CMD_LOAD, 1'b1, 1'b0, 1'b0, 1, 2, 3);
        for (int i = 0; i < 12; i++)
            queue_req(CMD_SOURCE, 1'b0, 1'b1, 1'b0, rand_coord(), rand_coord(), rand_coord());
        hold_go = 1'b1;
        drain_core();
        tx_idle = 1'b1;

        // no idling on either side for a stretch
        rx_idle = 1'b0;
        tx_idle = 1'b0;
        write_range(50000);
        random_frames(2);
        rx_idle = 1'b1;
        tx_idle = 1'b1;
        write_range(RANGE_TOP);
        random_frames(1);

        write_range(RANGE_TOP);
        random_frames(1);

        drain_core();
        repeat (200) @(posedge clk);
        $display("covered %0d requests and %0d results: empty store, target restarts,",
                 sent_items, results_seen);
        $display("range cutoff extremes, invalid points, back-to-back and long hold-off");
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[files.f]
src/nnrms_pkg.sv
src/nnrms_ram.sv
src/nnrms_finish.sv
src/nearest_neighbor_rms_error_core.sv
verif/tb_top.sv
